@@ hdl/adaptive_gain_scheduler_macros.svh @@
// Assertion macros used by the checker of the adaptive gain scheduler.
`ifndef ADAPTIVE_GAIN_SCHEDULER_MACROS_SVH
`define ADAPTIVE_GAIN_SCHEDULER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define AGS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define AGS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ hdl/ags_pkg.sv @@
// Types and constants shared by the adaptive gain scheduler modules.
package ags_pkg;

   localparam int DIV_NUM_W = 43;
   localparam int DIV_DEN_W = 38;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      FUNC_RESTART = 2'd0,
      FUNC_STEPS   = 2'd1,
      FUNC_UPDATE  = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      REG_WINDOW      = 3'd0,
      REG_ALPHA       = 3'd1,
      REG_RATE_LOW    = 3'd2,
      REG_RATE_HIGH   = 3'd3,
      REG_ADAPT_EN    = 3'd4,
      REG_SCALE_STEP  = 3'd5,
      REG_KP_BOUNDS   = 3'd6,
      REG_STEP_BOUNDS = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RATE_DIV,
      ST_RATE_SAT,
      ST_MIX_A,
      ST_MIX_B,
      ST_MIX_SUM,
      ST_ADAPT,
      ST_LO_DIV,
      ST_HI_DIV,
      ST_CLAMP,
      ST_MUL_KP,
      ST_MUL_MS,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ hdl/ags_div.sv @@
// Shared restoring divider producing one quotient bit per cycle.
module ags_div #(
   parameter int NumW = ags_pkg::DIV_NUM_W,
   parameter int DenW = ags_pkg::DIV_DEN_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NumW-1:0]      dividend,
   input  logic [DenW-1:0]      divisor,
   output logic [NumW-1:0]      quotient,
   output ags_pkg::div_stat_type status
);
   import ags_pkg::*;

   localparam int CntW = $clog2(NumW + 1);

   logic [NumW-1:0] num_ff, num_in;
   logic [DenW-1:0] rem_ff, rem_in;
   logic [DenW-1:0] den_ff, den_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DenW:0]   trial;
   logic [DenW:0]   diff;
   logic            fits;

   always_comb begin
      trial  = {rem_ff, num_ff[NumW-1]};
      diff   = trial - {1'b0, den_ff};
      fits   = trial >= {1'b0, den_ff};
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], fits};
         rem_in = fits ? diff[DenW-1:0] : trial[DenW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = num_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ hdl/adaptive_gain_scheduler.sv @@
// Restart and steps-sent items are taken in the idle state; the block is ready again in the next cycle.
// An update item runs the shared 43-step divider twice for the Kp bounds, then clamps the scale
// and forms the outputs; closing a sample with a rate adds a rate division, averaging the mix steps.
// A finished result waits in an output register while the next item is taken.
// Synchronous active-high reset restores the registers' defaults and a scale of 1.0.
module adaptive_gain_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // now_ms[31:0], room_temp[47:32], steps_sent[55:48], fast_mode[56],
   // base_kp[72:57], base_max_steps[80:73], zero fill above
   input  logic [ags_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func[1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // kp_out[15:0], max_steps_out[23:16]
   output logic [ags_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ags_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ags_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ags_pkg::*;

   // Configuration registers
   logic [31:0]        window_ff;
   logic [16:0]        alpha_ff;
   logic signed [31:0] rate_low_ff;
   logic signed [31:0] rate_high_ff;
   logic               adapt_en_ff;
   logic [16:0]        scale_step_ff;
   logic [63:0]        kp_bounds_ff;
   logic [31:0]        step_bounds_ff;

   // Block state
   logic               open_ff, open_in;
   logic [31:0]        start_time_ff, start_time_in;
   logic signed [15:0] start_temp_ff, start_temp_in;
   logic signed [6:0]  steps_ff, steps_in;
   logic signed [31:0] avg_ff, avg_in;
   logic               avg_valid_ff, avg_valid_in;
   logic               adj_once_ff, adj_once_in;
   logic [31:0]        last_adj_ff, last_adj_in;
   logic [31:0]        scale_ff, scale_in;

   // Item and working registers
   logic [31:0]        now_ff;
   logic signed [15:0] temp_ff;
   logic               fast_ff;
   logic [15:0]        base_kp_ff;
   logic signed [7:0]  base_ms_ff;
   logic               neg_ff, neg_in;
   logic signed [31:0] rate_ff, rate_in;
   logic signed [49:0] prod_a_ff, prod_a_in;
   logic signed [49:0] prod_b_ff, prod_b_in;
   logic [31:0]        lo_ff, lo_in;
   logic [31:0]        hi_ff, hi_in;
   logic [47:0]        kp_prod_ff, kp_prod_in;
   logic [39:0]        ms_prod_ff, ms_prod_in;
   state_type          fsm_ff, fsm_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_kp_ff, rsp_kp_in;
   logic [7:0]         rsp_ms_ff, rsp_ms_in;

   // Divider interface
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_q;
   div_stat_type         div_stat;

   // Item fields
   func_type           req_func;
   logic [31:0]        req_now;
   logic signed [15:0] req_temp;
   logic signed [7:0]  req_steps;
   logic               req_accept;

   // Combinational helpers
   logic               item_load;
   logic signed [8:0]  step_sum;
   logic signed [6:0]  step_clamp;
   logic [31:0]        dt;
   logic signed [16:0] dtemp;
   logic [16:0]        dtemp_abs;
   logic [5:0]         step_mag;
   logic [25:0]        dtemp_k;
   logic [37:0]        rate_den;
   logic [16:0]        kdiv;
   logic [15:0]        kmin, kmax;
   logic signed [7:0]  smin, smax;
   logic [15:0]        bound_sel;
   logic [31:0]        q_sat;
   logic [16:0]        alpha_eff;
   logic signed [50:0] mix_sum;
   logic signed [50:0] mix_round;
   logic [32:0]        scale_add;
   logic [7:0]         ms_mag;
   logic [48:0]        kp_round;
   logic [40:0]        ms_round;
   logic signed [25:0] ms_signed;
   logic [15:0]        kp_final;
   logic signed [25:0] ms_final;

   assign req_func   = func_type'(req_tuser);
   assign req_now    = req_tdata[31:0];
   assign req_temp   = req_tdata[47:32];
   assign req_steps  = req_tdata[55:48];
   assign req_tready = (fsm_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ms_ff, rsp_kp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= 32'd60000;
         alpha_ff       <= 17'd19661;
         rate_low_ff    <= '0;
         rate_high_ff   <= '0;
         adapt_en_ff    <= 1'b0;
         scale_step_ff  <= 17'd3277;
         kp_bounds_ff   <= '0;
         step_bounds_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_WINDOW:      window_ff      <= csr_data[31:0];
            REG_ALPHA:       alpha_ff       <= csr_data[16:0];
            REG_RATE_LOW:    rate_low_ff    <= csr_data[31:0];
            REG_RATE_HIGH:   rate_high_ff   <= csr_data[31:0];
            REG_ADAPT_EN:    adapt_en_ff    <= csr_data[0];
            REG_SCALE_STEP:  scale_step_ff  <= csr_data[16:0];
            REG_KP_BOUNDS:   kp_bounds_ff   <= csr_data;
            REG_STEP_BOUNDS: step_bounds_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   ags_div #(
      .NumW(DIV_NUM_W),
      .DenW(DIV_DEN_W)
   ) u_ags_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (div_den),
      .quotient(div_q),
      .status  (div_stat)
   );

   always_comb begin
      kmin      = fast_ff ? kp_bounds_ff[47:32] : kp_bounds_ff[15:0];
      kmax      = fast_ff ? kp_bounds_ff[63:48] : kp_bounds_ff[31:16];
      smin      = fast_ff ? step_bounds_ff[23:16] : step_bounds_ff[7:0];
      smax      = fast_ff ? step_bounds_ff[31:24] : step_bounds_ff[15:8];
      kdiv      = (base_kp_ff == 16'd0) ? 17'd256 : {1'b0, base_kp_ff};

      dt        = now_ff - start_time_ff;
      dtemp     = 17'(temp_ff) - 17'(start_temp_ff);
      dtemp_abs = dtemp[16] ? 17'(-dtemp) : 17'(dtemp);
      step_mag  = steps_ff[6] ? 6'(-steps_ff) : steps_ff[5:0];
      if (step_mag == 6'd0) begin
         step_mag = 6'd1;
      end
      dtemp_k   = dtemp_abs[15:0] * 10'd1000;
      rate_den  = dt * step_mag;

      q_sat = div_q[31:0];
      if (!neg_ff && div_q > 43'h0_7FFF_FFFF) begin
         q_sat = 32'h7FFF_FFFF;
      end else if (neg_ff && div_q > 43'h0_8000_0000) begin
         q_sat = 32'h8000_0000;
      end

      alpha_eff = alpha_ff;
      if (alpha_ff < 17'd3277) begin
         alpha_eff = 17'd3277;
      end else if (alpha_ff > 17'd65536) begin
         alpha_eff = 17'd65536;
      end
      mix_sum   = 51'(prod_a_ff) + 51'(prod_b_ff);
      mix_round = (mix_sum + 51'sd32768) >>> 16;

      scale_add = 33'(scale_ff) + 33'(scale_step_ff);
      ms_mag    = base_ms_ff[7] ? 8'(-base_ms_ff) : 8'(base_ms_ff);

      kp_round  = 49'(kp_prod_ff) + 49'd32768;
      kp_final  = 16'(kp_round[48:16]);
      if (kp_round[48:16] < 33'(kmin)) begin
         kp_final = kmin;
      end else if (kp_round[48:16] > 33'(kmax)) begin
         kp_final = kmax;
      end
      ms_round  = 41'(ms_prod_ff) + 41'd32768;
      ms_signed = base_ms_ff[7] ? -$signed({1'b0, ms_round[40:16]})
                                : $signed({1'b0, ms_round[40:16]});
      ms_final  = ms_signed;
      if (ms_signed < 26'(smin)) begin
         ms_final = 26'(smin);
      end else if (ms_signed > 26'(smax)) begin
         ms_final = 26'(smax);
      end

      step_sum   = 9'(steps_ff) + 9'(req_steps);
      step_clamp = step_sum[6:0];
      if (step_sum > 9'sd32) begin
         step_clamp = 7'sd32;
      end else if (step_sum < -9'sd32) begin
         step_clamp = -7'sd32;
      end
   end

   always_comb begin
      fsm_in        = fsm_ff;
      open_in       = open_ff;
      start_time_in = start_time_ff;
      start_temp_in = start_temp_ff;
      steps_in      = steps_ff;
      avg_in        = avg_ff;
      avg_valid_in  = avg_valid_ff;
      adj_once_in   = adj_once_ff;
      last_adj_in   = last_adj_ff;
      scale_in      = scale_ff;
      neg_in        = neg_ff;
      rate_in       = rate_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      kp_prod_in    = kp_prod_ff;
      ms_prod_in    = ms_prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kp_in     = rsp_kp_ff;
      rsp_ms_in     = rsp_ms_ff;
      item_load     = 1'b0;
      div_start     = 1'b0;
      bound_sel     = kmin;
      div_num       = DIV_NUM_W'({dtemp_k, 16'd0}) + DIV_NUM_W'(rate_den[37:1]);
      div_den       = rate_den;

      unique case (fsm_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_load = 1'b1;
               unique case (req_func)
                  FUNC_RESTART: begin
                     open_in       = 1'b0;
                     start_time_in = req_now;
                     start_temp_in = req_temp;
                     steps_in      = '0;
                  end
                  FUNC_STEPS: begin
                     if (req_steps != 8'sd0) begin
                        if (!open_ff) begin
                           open_in       = 1'b1;
                           start_time_in = req_now;
                           start_temp_in = req_temp;
                           if (req_steps > 8'sd32) begin
                              steps_in = 7'sd32;
                           end else if (req_steps < -8'sd32) begin
                              steps_in = -7'sd32;
                           end else begin
                              steps_in = req_steps[6:0];
                           end
                        end else if (step_clamp == 7'sd0) begin
                           steps_in = req_steps[7] ? -7'sd1 : 7'sd1;
                        end else begin
                           steps_in = step_clamp;
                        end
                     end
                  end
                  FUNC_UPDATE: fsm_in = ST_CHECK;
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            neg_in = dtemp[16] != (steps_ff <= 7'sd0);
            if (open_ff && dt >= window_ff) begin
               open_in  = 1'b0;
               steps_in = '0;
               if (dt != 32'd0) begin
                  div_start = 1'b1;
                  fsm_in    = ST_RATE_DIV;
               end else begin
                  div_start = 1'b1;
                  fsm_in    = ST_LO_DIV;
               end
            end else begin
               div_start = 1'b1;
               fsm_in    = ST_LO_DIV;
            end
            if (fsm_in == ST_LO_DIV) begin
               div_num = DIV_NUM_W'({kmin, 16'd0}) + DIV_NUM_W'(kdiv[16:1]);
               div_den = DIV_DEN_W'(kdiv);
            end
         end
         ST_RATE_DIV: begin
            if (div_stat.done) begin
               fsm_in = ST_RATE_SAT;
            end
         end
         ST_RATE_SAT: begin
            rate_in = neg_ff ? -$signed(q_sat) : $signed(q_sat);
            if (!avg_valid_ff) begin
               avg_in       = rate_in;
               avg_valid_in = 1'b1;
               fsm_in       = ST_ADAPT;
            end else begin
               fsm_in = ST_MIX_A;
            end
         end
         ST_MIX_A: begin
            prod_a_in = $signed({1'b0, alpha_eff}) * rate_ff;
            fsm_in    = ST_MIX_B;
         end
         ST_MIX_B: begin
            prod_b_in = $signed({1'b0, 17'd65536 - alpha_eff}) * avg_ff;
            fsm_in    = ST_MIX_SUM;
         end
         ST_MIX_SUM: begin
            avg_in = mix_round[31:0];
            fsm_in = ST_ADAPT;
         end
         ST_ADAPT: begin
            if (adapt_en_ff && (!adj_once_ff || (now_ff - last_adj_ff) >= window_ff)) begin
               if (avg_ff < rate_low_ff) begin
                  scale_in    = scale_add[32] ? 32'hFFFF_FFFF : scale_add[31:0];
                  adj_once_in = 1'b1;
                  last_adj_in = now_ff;
               end else if (avg_ff > rate_high_ff) begin
                  scale_in    = (scale_ff > 32'(scale_step_ff)) ?
                                scale_ff - 32'(scale_step_ff) : 32'd0;
                  adj_once_in = 1'b1;
                  last_adj_in = now_ff;
               end
            end
            div_start = 1'b1;
            div_num   = DIV_NUM_W'({kmin, 16'd0}) + DIV_NUM_W'(kdiv[16:1]);
            div_den   = DIV_DEN_W'(kdiv);
            fsm_in    = ST_LO_DIV;
         end
         ST_LO_DIV: begin
            if (div_stat.done) begin
               lo_in     = div_q[31:0];
               bound_sel = kmax;
               div_start = 1'b1;
               div_num   = DIV_NUM_W'({bound_sel, 16'd0}) + DIV_NUM_W'(kdiv[16:1]);
               div_den   = DIV_DEN_W'(kdiv);
               fsm_in    = ST_HI_DIV;
            end
         end
         ST_HI_DIV: begin
            if (div_stat.done) begin
               hi_in  = div_q[31:0];
               fsm_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (scale_ff < lo_ff) begin
               scale_in = lo_ff;
            end else if (scale_ff > hi_ff) begin
               scale_in = hi_ff;
            end
            fsm_in = ST_MUL_KP;
         end
         ST_MUL_KP: begin
            kp_prod_in = base_kp_ff * scale_ff;
            fsm_in     = ST_MUL_MS;
         end
         ST_MUL_MS: begin
            ms_prod_in = ms_mag * scale_ff;
            fsm_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kp_in    = kp_final;
               rsp_ms_in    = ms_final[7:0];
               fsm_in       = ST_IDLE;
            end
         end
         default: fsm_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (item_load) begin
         now_ff     <= req_now;
         temp_ff    <= req_temp;
         fast_ff    <= req_tdata[56];
         base_kp_ff <= req_tdata[72:57];
         base_ms_ff <= req_tdata[80:73];
      end
      neg_ff     <= neg_in;
      rate_ff    <= rate_in;
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      kp_prod_ff <= kp_prod_in;
      ms_prod_ff <= ms_prod_in;
      rsp_kp_ff  <= rsp_kp_in;
      rsp_ms_ff  <= rsp_ms_in;
      if (reset) begin
         fsm_ff        <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         open_ff       <= 1'b0;
         start_time_ff <= '0;
         start_temp_ff <= '0;
         steps_ff      <= '0;
         avg_ff        <= '0;
         avg_valid_ff  <= 1'b0;
         adj_once_ff   <= 1'b0;
         last_adj_ff   <= '0;
         scale_ff      <= 32'd65536;
      end else begin
         fsm_ff        <= fsm_in;
         rsp_valid_ff  <= rsp_valid_in;
         open_ff       <= open_in;
         start_time_ff <= start_time_in;
         start_temp_ff <= start_temp_in;
         steps_ff      <= steps_in;
         avg_ff        <= avg_in;
         avg_valid_ff  <= avg_valid_in;
         adj_once_ff   <= adj_once_in;
         last_adj_ff   <= last_adj_in;
         scale_ff      <= scale_in;
      end
   end

endmodule

@@ hdl/ags_checker.sv @@
// Port-level assertion checker for the adaptive gain scheduler and its bind.
`include "adaptive_gain_scheduler_macros.svh"

module ags_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [1:0]                     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ags_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ags_pkg::*;

   `AGS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `AGS_ASSERT_NEXT(a_no_spurious, req_tvalid && req_tready && req_tuser != FUNC_UPDATE && !rsp_tvalid, !rsp_tvalid, "result without an update transfer")
   `AGS_ASSERT_NEXT(a_update_busy, req_tvalid && req_tready && req_tuser == FUNC_UPDATE, !req_tready, "ready during an update")
   `AGS_ASSERT_NOW(a_rsp_source, $rose(rsp_tvalid), $past(!req_tready), "result appeared while idle")

endmodule

bind adaptive_gain_scheduler ags_checker u_ags_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
